FILE: rtl/sst_pkg.sv
// Shared constants, codes and inter-module types for the subresource state tracker.
package sst_pkg;

  localparam int unsigned SUBRESOURCE_DEPTH = 64;

  localparam int unsigned STATE_W = 32;
  localparam int unsigned FIRST_W = 7;
  localparam int unsigned RANGE_W = 7;
  localparam int unsigned MIP_W   = 4;
  localparam int unsigned LAYER_W = 12;
  localparam int unsigned PLANE_W = 2;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned PROD_W  = MIP_W + LAYER_W;
  localparam int unsigned TOTAL_W = PROD_W + PLANE_W;

  typedef enum logic [0:0] {
    OP_INIT       = 1'b0,
    OP_TRANSITION = 1'b1
  } op_t;

  // walker -> emit stage
  typedef struct packed {
    logic               push;
    logic               flush;
    logic [INDEX_W-1:0] idx;
    logic [STATE_W-1:0] old_state;
    logic [STATE_W-1:0] new_state;
  } emit_ctl_t;

  // emit stage -> walker
  typedef struct packed {
    logic ready;
  } emit_sts_t;

endpackage

FILE: rtl/subresource_state_tracker_unit.sv
// Top level: sequencer that fills and walks the subresource state memory.
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_stall   operation, target_state, first_index,
//                                              range_count, mip_levels,
//                                              layer_or_depth_count, is_volume, plane_count
//   result    out        rsp_valid/rsp_stall   subresource_index, old_state, new_state, last
//
// Initialize writes the N in-use entries and transition walks a clamped range of R entries,
// one entry per cycle through the memory's single read/write port pair, with no result
// stalls; an empty range walks no entries.
// One request is in flight at a time; req_stall is high until it is done.
// A stalled result stalls the walk once the pending slot and output register are both full.
// Reset clears the in-use count to zero; memory contents are not cleared.
module subresource_state_tracker_unit #(
  parameter int unsigned SUBRESOURCE_DEPTH = sst_pkg::SUBRESOURCE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        operation,
  input  logic [sst_pkg::STATE_W-1:0] target_state,
  input  logic [sst_pkg::FIRST_W-1:0] first_index,
  input  logic [sst_pkg::RANGE_W-1:0] range_count,
  input  logic [sst_pkg::MIP_W-1:0]   mip_levels,
  input  logic [sst_pkg::LAYER_W-1:0] layer_or_depth_count,
  input  logic                        is_volume,
  input  logic [sst_pkg::PLANE_W-1:0] plane_count,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [sst_pkg::INDEX_W-1:0] subresource_index,
  output logic [sst_pkg::STATE_W-1:0] old_state,
  output logic [sst_pkg::STATE_W-1:0] new_state,
  output logic                        last
);

  localparam int unsigned CNT_W = $clog2(SUBRESOURCE_DEPTH + 1);
  localparam int unsigned AW    = (SUBRESOURCE_DEPTH > 1) ? $clog2(SUBRESOURCE_DEPTH) : 1;
  localparam int unsigned SW    = ((CNT_W > sst_pkg::FIRST_W) ? CNT_W : sst_pkg::FIRST_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_CALC,
    ST_INIT_FILL,
    ST_WALK,
    ST_FLUSH
  } st_t;

  st_t                         state;
  logic [CNT_W-1:0]            in_use;
  logic [CNT_W-1:0]            walk_idx;
  logic [CNT_W-1:0]            walk_end;
  logic [sst_pkg::STATE_W-1:0] target;
  logic [sst_pkg::PROD_W-1:0]  prod;
  logic [sst_pkg::PLANE_W-1:0] planes;
  logic                        cmp_vld;
  logic [AW-1:0]               cmp_idx;

  logic [sst_pkg::LAYER_W-1:0] layers_eff;
  logic [sst_pkg::PROD_W-1:0]  prod_next;
  logic [sst_pkg::TOTAL_W-1:0] total;
  logic [CNT_W-1:0]            sat_count;
  logic [SW-1:0]               first_w;
  logic [SW-1:0]               range_w;
  logic [SW-1:0]               use_w;
  logic [SW-1:0]               rem_w;
  logic                        range_empty;
  logic [CNT_W-1:0]            start_next;
  logic [CNT_W-1:0]            end_next;

  logic                        issue;
  logic                        differ;
  logic                        cmp_fire;
  logic                        walk_we;
  logic                        fill_we;
  logic                        mem_we;
  logic [AW-1:0]               waddr;
  logic [sst_pkg::STATE_W-1:0] rdata;

  sst_pkg::emit_ctl_t          ctl;
  sst_pkg::emit_sts_t          sts;

  assign req_stall = (state != ST_IDLE);

  // initialize size: mips * layers registered, then times planes by shift/add
  always_comb begin
    layers_eff = is_volume ? sst_pkg::LAYER_W'(1) : layer_or_depth_count;
    prod_next  = sst_pkg::PROD_W'(mip_levels) * sst_pkg::PROD_W'(layers_eff);
    total      = (planes[0] ? sst_pkg::TOTAL_W'(prod) : '0)
               + (planes[1] ? sst_pkg::TOTAL_W'({prod, 1'b0}) : '0);
    sat_count  = (total > sst_pkg::TOTAL_W'(SUBRESOURCE_DEPTH)) ?
                 CNT_W'(SUBRESOURCE_DEPTH) : CNT_W'(total);
  end

  // transition range clamp; empty range collapses to start == end
  always_comb begin
    first_w     = SW'(first_index);
    range_w     = SW'(range_count);
    use_w       = SW'(in_use);
    rem_w       = use_w - first_w;
    range_empty = first_w > use_w;
    start_next  = range_empty ? in_use : CNT_W'(first_w);
    if (range_empty || (range_w > rem_w)) begin
      end_next = in_use;
    end else begin
      end_next = CNT_W'(first_w + range_w);
    end
  end

  assign differ   = (rdata != target);
  assign cmp_fire = cmp_vld && (!differ || sts.ready);
  assign issue    = (state == ST_WALK) && (walk_idx != walk_end) && (!cmp_vld || cmp_fire);
  assign walk_we  = cmp_vld && differ && sts.ready;
  assign fill_we  = (state == ST_INIT_FILL) && (walk_idx != walk_end);
  assign mem_we   = walk_we || fill_we;
  assign waddr    = fill_we ? walk_idx[AW-1:0] : cmp_idx;

  assign ctl.push      = walk_we;
  assign ctl.flush     = (state == ST_FLUSH);
  assign ctl.idx       = sst_pkg::INDEX_W'(cmp_idx);
  assign ctl.old_state = rdata;
  assign ctl.new_state = target;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      in_use  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            target <= target_state;
            if (operation == sst_pkg::OP_TRANSITION) begin
              walk_idx <= start_next;
              walk_end <= end_next;
              state    <= ST_WALK;
            end else begin
              prod   <= prod_next;
              planes <= plane_count;
              state  <= ST_INIT_CALC;
            end
          end
        end
        ST_INIT_CALC: begin
          in_use   <= sat_count;
          walk_idx <= '0;
          walk_end <= sat_count;
          state    <= ST_INIT_FILL;
        end
        ST_INIT_FILL: begin
          if (walk_idx == walk_end) begin
            state <= ST_IDLE;
          end else begin
            walk_idx <= walk_idx + CNT_W'(1);
          end
        end
        ST_WALK: begin
          if (issue) begin
            walk_idx <= walk_idx + CNT_W'(1);
            cmp_vld  <= 1'b1;
            cmp_idx  <= walk_idx[AW-1:0];
          end else if (cmp_fire) begin
            cmp_vld <= 1'b0;
          end
          if ((walk_idx == walk_end) && !cmp_vld) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (sts.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sst_ram #(
    .DEPTH (SUBRESOURCE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (target),
    .re    (issue),
    .raddr (walk_idx[AW-1:0]),
    .rdata (rdata)
  );

  sst_emit u_emit (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .sts               (sts),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .subresource_index (subresource_index),
    .old_state         (old_state),
    .new_state         (new_state),
    .last              (last)
  );

  a_in_use_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= CNT_W'(SUBRESOURCE_DEPTH))
    else $error("in-use count above table depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (walk_idx <= walk_end))
    else $error("walk index ran past range end");

  a_flush_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> !cmp_vld)
    else $error("flush with compare stage still busy");

  a_block_needs_output: assert property (@(posedge clk) disable iff (rst)
    !sts.ready |-> (rsp_valid && rsp_stall))
    else $error("emit stage blocked without a stalled result");

endmodule

FILE: rtl/sst_ram.sv
// State word memory: one write port, one read port with registered read data.
module sst_ram #(
  parameter int unsigned DEPTH = sst_pkg::SUBRESOURCE_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [sst_pkg::STATE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [sst_pkg::STATE_W-1:0] rdata
);

  logic [sst_pkg::STATE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sst_emit.sv
// Result stage: holds one pending transition so the final one can be flagged last.
module sst_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  sst_pkg::emit_ctl_t          ctl,
  output sst_pkg::emit_sts_t          sts,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [sst_pkg::INDEX_W-1:0] subresource_index,
  output logic [sst_pkg::STATE_W-1:0] old_state,
  output logic [sst_pkg::STATE_W-1:0] new_state,
  output logic                        last
);

  logic                        p_vld;
  logic [sst_pkg::INDEX_W-1:0] p_idx;
  logic [sst_pkg::STATE_W-1:0] p_old;
  logic [sst_pkg::STATE_W-1:0] p_new;
  logic                        ready;
  logic                        load;

  assign ready     = !p_vld || !rsp_valid || !rsp_stall;
  assign sts.ready = ready;
  // pending moves out when a newer one arrives or the walk ends
  assign load      = p_vld && (ctl.push || ctl.flush) && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid         <= 1'b1;
        subresource_index <= p_idx;
        old_state         <= p_old;
        new_state         <= p_new;
        last              <= ctl.flush;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (ctl.push) begin
        p_vld <= 1'b1;
        p_idx <= ctl.idx;
        p_old <= ctl.old_state;
        p_new <= ctl.new_state;
      end else if (ctl.flush && ready) begin
        p_vld <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/subresource_state_tracker_unit_tb.sv
// Self-checking testbench for the subresource state tracker: predictor, scoreboard, stimulus.
module subresource_state_tracker_unit_tb;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 107;
  localparam int unsigned CALM_ITEMS    = 20;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned DRAIN_CYCLES  = 100;

  typedef struct packed {
    sst_pkg::op_t                operation;
    logic [sst_pkg::STATE_W-1:0] target_state;
    logic [sst_pkg::FIRST_W-1:0] first_index;
    logic [sst_pkg::RANGE_W-1:0] range_count;
    logic [sst_pkg::MIP_W-1:0]   mip_levels;
    logic [sst_pkg::LAYER_W-1:0] layer_or_depth_count;
    logic                        is_volume;
    logic [sst_pkg::PLANE_W-1:0] plane_count;
  } tracker_req_t;

  typedef struct packed {
    logic [sst_pkg::INDEX_W-1:0] subresource_index;
    logic [sst_pkg::STATE_W-1:0] old_state;
    logic [sst_pkg::STATE_W-1:0] new_state;
    logic                        last;
  } state_change_t;

  class tracker_scoreboard;
    logic [sst_pkg::STATE_W-1:0] state_table [sst_pkg::SUBRESOURCE_DEPTH];
    int unsigned                 in_use = 0;
    state_change_t               pending_changes [$];
    int unsigned                 failures = 0;

    // predicts the state changes caused by one accepted request
    function void note_request(tracker_req_t r);
      int unsigned   mips;
      int unsigned   layers;
      int unsigned   planes;
      int unsigned   total;
      int unsigned   span;
      int unsigned   stop;
      int unsigned   last_hit;
      state_change_t c;
      if (r.operation == sst_pkg::OP_INIT) begin
        mips   = r.mip_levels;
        layers = r.is_volume ? 1 : r.layer_or_depth_count;
        planes = r.plane_count;
        total  = mips * layers * planes;
        if (total > sst_pkg::SUBRESOURCE_DEPTH) total = sst_pkg::SUBRESOURCE_DEPTH;
        in_use = total;
        for (int i = 0; i < in_use; i++) state_table[i] = r.target_state;
      end else if (r.first_index <= in_use) begin
        span = r.range_count;
        if (span > in_use - r.first_index) span = in_use - r.first_index;
        stop = r.first_index + span;
        last_hit = sst_pkg::SUBRESOURCE_DEPTH;
        for (int i = r.first_index; i < stop; i++) begin
          if (state_table[i] != r.target_state) last_hit = i;
        end
        for (int i = r.first_index; i < stop; i++) begin
          if (state_table[i] != r.target_state) begin
            c.subresource_index = sst_pkg::INDEX_W'(i);
            c.old_state         = state_table[i];
            c.new_state         = r.target_state;
            c.last              = (i == last_hit);
            pending_changes.push_back(c);
            state_table[i] = r.target_state;
          end
        end
      end
    endfunction

    function void check_result(state_change_t got);
      state_change_t exp;
      if (pending_changes.size() == 0) begin
        $error("unexpected result: index %0d old %h new %h last %0b",
               got.subresource_index, got.old_state, got.new_state, got.last);
        failures++;
        return;
      end
      exp = pending_changes.pop_front();
      if (got.subresource_index !== exp.subresource_index) begin
        $error("subresource_index mismatch: expected %0d, actual %0d",
               exp.subresource_index, got.subresource_index);
        failures++;
      end
      if (got.old_state !== exp.old_state) begin
        $error("old_state mismatch: expected %h, actual %h", exp.old_state, got.old_state);
        failures++;
      end
      if (got.new_state !== exp.new_state) begin
        $error("new_state mismatch: expected %h, actual %h", exp.new_state, got.new_state);
        failures++;
      end
      if (got.last !== exp.last) begin
        $error("last mismatch: expected %0b, actual %0b", exp.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        req_valid;
  logic                        req_stall;
  logic                        operation;
  logic [sst_pkg::STATE_W-1:0] target_state;
  logic [sst_pkg::FIRST_W-1:0] first_index;
  logic [sst_pkg::RANGE_W-1:0] range_count;
  logic [sst_pkg::MIP_W-1:0]   mip_levels;
  logic [sst_pkg::LAYER_W-1:0] layer_or_depth_count;
  logic                        is_volume;
  logic [sst_pkg::PLANE_W-1:0] plane_count;
  logic                        rsp_valid;
  logic                        rsp_stall;
  logic [sst_pkg::INDEX_W-1:0] subresource_index;
  logic [sst_pkg::STATE_W-1:0] old_state;
  logic [sst_pkg::STATE_W-1:0] new_state;
  logic                        last;

  tracker_scoreboard sb = new;
  bit                calm;
  bit                hold_results;
  bit                hold_done;
  int unsigned       cycle_count;

  subresource_state_tracker_unit dut (
    .clk                  (clk),
    .rst                  (rst),
    .req_valid            (req_valid),
    .req_stall            (req_stall),
    .operation            (operation),
    .target_state         (target_state),
    .first_index          (first_index),
    .range_count          (range_count),
    .mip_levels           (mip_levels),
    .layer_or_depth_count (layer_or_depth_count),
    .is_volume            (is_volume),
    .plane_count          (plane_count),
    .rsp_valid            (rsp_valid),
    .rsp_stall            (rsp_stall),
    .subresource_index    (subresource_index),
    .old_state            (old_state),
    .new_state            (new_state),
    .last                 (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("subresource_state_tracker_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_result({subresource_index, old_state, new_state, last});
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results && !hold_done) begin
        hold_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic logic [sst_pkg::STATE_W-1:0] pick_state();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hA5A5_A5A5;
      default: return $urandom();
    endcase
  endfunction

  function automatic tracker_req_t make_init(logic [sst_pkg::STATE_W-1:0] st,
                                             int unsigned mips, int unsigned layers,
                                             bit vol, int unsigned planes);
    tracker_req_t r;
    r.operation            = sst_pkg::OP_INIT;
    r.target_state         = st;
    r.first_index          = sst_pkg::FIRST_W'($urandom());
    r.range_count          = sst_pkg::RANGE_W'($urandom());
    r.mip_levels           = sst_pkg::MIP_W'(mips);
    r.layer_or_depth_count = sst_pkg::LAYER_W'(layers);
    r.is_volume            = vol;
    r.plane_count          = sst_pkg::PLANE_W'(planes);
    return r;
  endfunction

  function automatic tracker_req_t make_transition(logic [sst_pkg::STATE_W-1:0] st,
                                                   int unsigned first, int unsigned count);
    tracker_req_t r;
    r.operation            = sst_pkg::OP_TRANSITION;
    r.target_state         = st;
    r.first_index          = sst_pkg::FIRST_W'(first);
    r.range_count          = sst_pkg::RANGE_W'(count);
    r.mip_levels           = sst_pkg::MIP_W'($urandom());
    r.layer_or_depth_count = sst_pkg::LAYER_W'($urandom());
    r.is_volume            = 1'($urandom());
    r.plane_count          = sst_pkg::PLANE_W'($urandom());
    return r;
  endfunction

  // called at a clock edge; waits for the edge where the transaction is accepted, then may idle req_valid at random
  task automatic send_request(input tracker_req_t r);
    req_valid            <= 1'b1;
    operation            <= r.operation;
    target_state         <= r.target_state;
    first_index          <= r.first_index;
    range_count          <= r.range_count;
    mip_levels           <= r.mip_levels;
    layer_or_depth_count <= r.layer_or_depth_count;
    is_volume            <= r.is_volume;
    plane_count          <= r.plane_count;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_changes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_transition();
    int unsigned first;
    int unsigned count;
    first = (sb.in_use == 0) ? 0 : $urandom_range(0, sb.in_use);
    count = $urandom_range(0, sb.in_use - first + 3);
    send_request(make_transition(pick_state(), first, count));
  endtask

  initial begin
    int unsigned  items;
    tracker_req_t r;
    calm                 = 1'b0;
    hold_results         <= 1'b0;
    rst                  <= 1'b1;
    req_valid            <= 1'b0;
    operation            <= sst_pkg::OP_INIT;
    target_state         <= '0;
    first_index          <= '0;
    range_count          <= '0;
    mip_levels           <= '0;
    layer_or_depth_count <= '0;
    is_volume            <= 1'b0;
    plane_count          <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, zero dimensions, clamping, saturation, skipped entries
    send_request(make_transition(32'hFFFF_FFFF, 0, 64));
    send_request(make_init(32'h1111_1111, 0, 5, 0, 2));
    send_request(make_init(32'h2222_2222, 3, 5, 0, 0));
    send_request(make_init(32'h3333_3333, 3, 0, 0, 2));
    send_request(make_init(32'h0000_0000, 3, 0, 1, 2));
    send_request(make_transition(32'hFFFF_FFFF, 0, 127));
    send_request(make_transition(32'h0000_0001, 6, 5));
    send_request(make_transition(32'h0000_0001, 7, 5));
    send_request(make_transition(32'hFFFF_FFFF, 2, 2));
    send_request(make_transition(32'h0000_0000, 1, 3));
    send_request(make_init(32'hA5A5_A5A5, 15, 4095, 0, 3));
    send_request(make_transition(32'h5A5A_5A5A, 0, 64));
    send_request(make_transition(32'h0000_0000, 63, 1));
    send_request(make_transition(32'hFFFF_FFFF, 127, 127));
    send_request(make_init(32'h1234_5678, 1, 1, 0, 1));
    send_request(make_transition(32'h8765_4321, 0, 127));
    send_request(make_init(32'hFFFF_FFFF, 15, 4095, 1, 3));
    send_request(make_transition(32'h0000_0000, 40, 10));
    send_request(make_transition(32'h0000_0000, 0, 0));
    send_request(make_init(32'h0000_0000, 8, 8, 0, 1));
    send_request(make_transition(32'h8000_0000, 0, 64));
    send_request(make_transition(32'h0000_0001, 10, 5));
    send_request(make_transition(32'h0000_0001, 0, 64));

    // sender holds off until everything outstanding has come back
    req_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // long result stall while full-table walks keep coming
    hold_results <= 1'b1;
    items = 0;
    send_request(make_init(32'hC3C3_C3C3, 4, 16, 0, 1));
    for (int k = 0; k < 3; k++) begin
      send_request(make_transition(pick_state() ^ k, 0, 64));
      items++;
    end
    items++;

    while (items < RANDOM_ITEMS) begin
      if (items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 6) == 0) begin
        r.operation            = sst_pkg::op_t'($urandom_range(0, 1));
        r.target_state         = $urandom();
        r.first_index          = sst_pkg::FIRST_W'($urandom());
        r.range_count          = sst_pkg::RANGE_W'($urandom());
        r.mip_levels           = sst_pkg::MIP_W'($urandom());
        r.layer_or_depth_count = sst_pkg::LAYER_W'($urandom());
        r.is_volume            = 1'($urandom());
        r.plane_count          = sst_pkg::PLANE_W'($urandom());
        send_request(r);
        items++;
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          send_request(make_init(pick_state(), $urandom_range(0, 15), $urandom_range(0, 4095),
                                 1'($urandom_range(0, 1)), $urandom_range(0, 3)));
        end else begin
          send_request(make_init(pick_state(), $urandom_range(1, 4), $urandom_range(1, 6),
                                 1'($urandom_range(0, 1)), $urandom_range(1, 2)));
        end
        items++;
        repeat ($urandom_range(1, 5)) begin
          send_random_transition();
          items++;
        end
      end
    end

    req_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending_changes.size() == 0) begin
      $display("subresource_state_tracker_unit regression: pass");
    end else begin
      $display("subresource_state_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule
